>>> hw/rtl/nlnc_pkg.sv
package nlnc_pkg;

  // default coordinate width
  localparam int COORD_WIDTH_DEF = 16;

  // four interpolations run side by side: start x, start y, end x, end y
  localparam int NUM_LANES = 4;

  // window register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

  // window after reset (truncated to the coordinate width)
  localparam int RST_CLIP_LEFT   = 0;
  localparam int RST_CLIP_TOP    = 0;
  localparam int RST_CLIP_RIGHT  = 639;
  localparam int RST_CLIP_BOTTOM = 479;

endpackage

>>> hw/rtl/nlnc_div.sv
// Restoring divider, one quotient bit per stage, NUM_LANES lanes in lockstep.
// Dividend must stay below divisor * 2^(CW+1) for an exact quotient.
module nlnc_div import nlnc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int SW = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [NUM_LANES-1:0][2*CW+1:0]      num_i,
  input  logic [NUM_LANES-1:0][CW:0]          den_i,
  input  logic [SW-1:0]                       side_i,
  output logic                                vld_o,
  output logic [NUM_LANES-1:0][CW:0]          quot_o,
  output logic [NUM_LANES-1:0]                rnz_o,
  output logic [SW-1:0]                       side_o
);

  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int QW = EW;

  logic                              vld_s  [QW+1];
  logic [NUM_LANES-1:0][PW-1:0]      rem_s  [QW+1];
  logic [NUM_LANES-1:0][EW-1:0]      den_s  [QW+1];
  logic [NUM_LANES-1:0][QW-1:0]      quo_s  [QW+1];
  logic [SW-1:0]                     side_s [QW+1];

  assign vld_s[0]  = vld_i;
  assign rem_s[0]  = num_i;
  assign den_s[0]  = den_i;
  assign quo_s[0]  = '0;
  assign side_s[0] = side_i;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;

    logic                          vld_q;
    logic [NUM_LANES-1:0][PW-1:0]  rem_d, rem_q;
    logic [NUM_LANES-1:0][EW-1:0]  den_q;
    logic [NUM_LANES-1:0][QW-1:0]  quo_d, quo_q;
    logic [SW-1:0]                 side_q;

    always_comb begin
      logic [PW-1:0] sh;
      logic          ge;
      for (int l = 0; l < NUM_LANES; l++) begin
        sh       = PW'(den_s[j][l]) << K;
        ge       = (rem_s[j][l] >= sh);
        rem_d[l] = ge ? (rem_s[j][l] - sh) : rem_s[j][l];
        quo_d[l] = {quo_s[j][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        den_q  <= den_s[j];
        quo_q  <= quo_d;
        side_q <= side_s[j];
      end
    end

    assign vld_s[j+1]  = vld_q;
    assign rem_s[j+1]  = rem_q;
    assign den_s[j+1]  = den_q;
    assign quo_s[j+1]  = quo_q;
    assign side_s[j+1] = side_q;
  end

  assign vld_o  = vld_s[QW];
  assign quot_o = quo_s[QW];
  assign side_o = side_s[QW];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      rnz_o[l] = |rem_s[QW][l];
    end
  end

endmodule

>>> hw/rtl/nln_line_clipper_top.sv
// Channel  | Direction | Words carry
// ---------+-----------+-----------------------------------------------------
// s_axis   | in        | one segment: start_x, start_y, end_x, end_y
// m_axis   | out       | clipped segment, tuser = visible
// cfg      | in        | window edge write: left, top, right, bottom
//
// One segment enters per cycle while the output is not stalled; the pipeline is five front
// stages, one divider stage per quotient bit, and the output register.
// The quotient bit stages of the four-lane divider set the depth.
// Reset (async, active low) clears all valid bits and loads the default window.
// A stalled output freezes the whole pipeline in place; nothing is dropped.
module nln_line_clipper_top import nlnc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // start_x, start_y, end_x, end_y (lowest bits first)
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // visible
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                   cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]                 cfg_data_i
);

  localparam int CW  = COORD_WIDTH;
  localparam int EW  = CW + 1;       // differences of two coordinates
  localparam int PW  = 2 * EW;       // cross products
  localparam int TW  = CW + 2;       // interpolation sum before truncation
  localparam int TDW = ((4*CW+7)/8)*8;
  localparam int SW  = 2*CW + 3;     // divider sideband: visible, x1, y1, sx, sy

  // ---------------------------------------------------------------- window
  logic signed [CW-1:0] left_q, top_q, right_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= CW'(RST_CLIP_LEFT);
      top_q    <= CW'(RST_CLIP_TOP);
      right_q  <= CW'(RST_CLIP_RIGHT);
      bottom_q <= CW'(RST_CLIP_BOTTOM);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLIP_LEFT:   left_q   <= cfg_data_i;
        REG_CLIP_TOP:    top_q    <= cfg_data_i;
        REG_CLIP_RIGHT:  right_q  <= cfg_data_i;
        REG_CLIP_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  // Global advance: every stage moves when the output register is empty or its word is being taken.
  logic out_vld_q;
  logic adv;
  assign adv           = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------- stage 1
  // Differences and edge distances.
  logic signed [CW-1:0] in_x1, in_y1, in_x2, in_y2;
  assign in_x1 = s_axis_tdata[CW-1:0];
  assign in_y1 = s_axis_tdata[2*CW-1:CW];
  assign in_x2 = s_axis_tdata[3*CW-1:2*CW];
  assign in_y2 = s_axis_tdata[4*CW-1:3*CW];

  logic                 s1_vld_q;
  logic signed [CW-1:0] s1_x1_q, s1_y1_q;
  logic signed [EW-1:0] s1_dx_q, s1_dy_q, s1_ql_q, s1_qr_q, s1_qt_q, s1_qb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (adv) s1_vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x1_q <= in_x1;
      s1_y1_q <= in_y1;
      s1_dx_q <= EW'(in_x2) - EW'(in_x1);
      s1_dy_q <= EW'(in_y2) - EW'(in_y1);
      s1_ql_q <= EW'(in_x1) - EW'(left_q);
      s1_qr_q <= EW'(right_q) - EW'(in_x1);
      s1_qt_q <= EW'(in_y1) - EW'(top_q);
      s1_qb_q <= EW'(bottom_q) - EW'(in_y1);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Per axis: entry fraction clamped to >= 0, exit fraction clamped to <= 1.
  // A negative exit or a parallel segment outside the slab kills the segment.
  logic [EW-1:0] c_adx, c_ady;
  logic [EW-1:0] c_enx_n, c_enx_d, c_eny_n, c_eny_d;
  logic [EW-1:0] c_exx_n, c_exx_d, c_exy_n, c_exy_d;
  logic          c_ok;

  always_comb begin
    logic signed [EW-1:0] en_x, ex_x, en_y, ex_y;
    logic                 okx, oky;
    c_adx = s1_dx_q[EW-1] ? EW'(-s1_dx_q) : EW'(s1_dx_q);
    c_ady = s1_dy_q[EW-1] ? EW'(-s1_dy_q) : EW'(s1_dy_q);
    en_x  = (s1_dx_q > 0) ? -s1_ql_q : -s1_qr_q;
    ex_x  = (s1_dx_q > 0) ?  s1_qr_q :  s1_ql_q;
    en_y  = (s1_dy_q > 0) ? -s1_qt_q : -s1_qb_q;
    ex_y  = (s1_dy_q > 0) ?  s1_qb_q :  s1_qt_q;

    c_enx_n = '0;
    c_enx_d = EW'(1);
    c_exx_n = EW'(1);
    c_exx_d = EW'(1);
    okx     = 1'b1;
    if (s1_dx_q == '0) begin
      okx = (s1_ql_q >= 0) && (s1_qr_q >= 0);
    end else begin
      if (en_x > 0) begin
        c_enx_n = EW'(en_x);
        c_enx_d = c_adx;
      end
      if (ex_x < 0) begin
        okx = 1'b0;
      end else if (ex_x < $signed(c_adx)) begin
        c_exx_n = EW'(ex_x);
        c_exx_d = c_adx;
      end
    end

    c_eny_n = '0;
    c_eny_d = EW'(1);
    c_exy_n = EW'(1);
    c_exy_d = EW'(1);
    oky     = 1'b1;
    if (s1_dy_q == '0) begin
      oky = (s1_qt_q >= 0) && (s1_qb_q >= 0);
    end else begin
      if (en_y > 0) begin
        c_eny_n = EW'(en_y);
        c_eny_d = c_ady;
      end
      if (ex_y < 0) begin
        oky = 1'b0;
      end else if (ex_y < $signed(c_ady)) begin
        c_exy_n = EW'(ex_y);
        c_exy_d = c_ady;
      end
    end
    c_ok = okx & oky;
  end

  logic                 s2_vld_q, s2_ok_q, s2_sx_q, s2_sy_q;
  logic signed [CW-1:0] s2_x1_q, s2_y1_q;
  logic [EW-1:0]        s2_adx_q, s2_ady_q;
  logic [EW-1:0]        s2_enx_n_q, s2_enx_d_q, s2_eny_n_q, s2_eny_d_q;
  logic [EW-1:0]        s2_exx_n_q, s2_exx_d_q, s2_exy_n_q, s2_exy_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (adv) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ok_q    <= c_ok;
      s2_sx_q    <= s1_dx_q[EW-1];
      s2_sy_q    <= s1_dy_q[EW-1];
      s2_x1_q    <= s1_x1_q;
      s2_y1_q    <= s1_y1_q;
      s2_adx_q   <= c_adx;
      s2_ady_q   <= c_ady;
      s2_enx_n_q <= c_enx_n;
      s2_enx_d_q <= c_enx_d;
      s2_eny_n_q <= c_eny_n;
      s2_eny_d_q <= c_eny_d;
      s2_exx_n_q <= c_exx_n;
      s2_exx_d_q <= c_exx_d;
      s2_exy_n_q <= c_exy_n;
      s2_exy_d_q <= c_exy_d;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Cross products to rank the x and y fractions.
  logic                 s3_vld_q, s3_ok_q, s3_sx_q, s3_sy_q;
  logic signed [CW-1:0] s3_x1_q, s3_y1_q;
  logic [EW-1:0]        s3_adx_q, s3_ady_q;
  logic [EW-1:0]        s3_enx_n_q, s3_enx_d_q, s3_eny_n_q, s3_eny_d_q;
  logic [EW-1:0]        s3_exx_n_q, s3_exx_d_q, s3_exy_n_q, s3_exy_d_q;
  logic [PW-1:0]        s3_pen_x_q, s3_pen_y_q, s3_pex_x_q, s3_pex_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (adv) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ok_q    <= s2_ok_q;
      s3_sx_q    <= s2_sx_q;
      s3_sy_q    <= s2_sy_q;
      s3_x1_q    <= s2_x1_q;
      s3_y1_q    <= s2_y1_q;
      s3_adx_q   <= s2_adx_q;
      s3_ady_q   <= s2_ady_q;
      s3_enx_n_q <= s2_enx_n_q;
      s3_enx_d_q <= s2_enx_d_q;
      s3_eny_n_q <= s2_eny_n_q;
      s3_eny_d_q <= s2_eny_d_q;
      s3_exx_n_q <= s2_exx_n_q;
      s3_exx_d_q <= s2_exx_d_q;
      s3_exy_n_q <= s2_exy_n_q;
      s3_exy_d_q <= s2_exy_d_q;
      s3_pen_x_q <= PW'(s2_enx_n_q) * PW'(s2_eny_d_q);
      s3_pen_y_q <= PW'(s2_eny_n_q) * PW'(s2_enx_d_q);
      s3_pex_x_q <= PW'(s2_exx_n_q) * PW'(s2_exy_d_q);
      s3_pex_y_q <= PW'(s2_exy_n_q) * PW'(s2_exx_d_q);
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Entry = larger entry fraction, exit = smaller exit fraction.
  logic                 s4_vld_q, s4_ok_q, s4_sx_q, s4_sy_q;
  logic signed [CW-1:0] s4_x1_q, s4_y1_q;
  logic [EW-1:0]        s4_adx_q, s4_ady_q;
  logic [EW-1:0]        s4_n0_q, s4_d0_q, s4_n1_q, s4_d1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (adv) s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_ok_q  <= s3_ok_q;
      s4_sx_q  <= s3_sx_q;
      s4_sy_q  <= s3_sy_q;
      s4_x1_q  <= s3_x1_q;
      s4_y1_q  <= s3_y1_q;
      s4_adx_q <= s3_adx_q;
      s4_ady_q <= s3_ady_q;
      if (s3_pen_x_q > s3_pen_y_q) begin
        s4_n0_q <= s3_enx_n_q;
        s4_d0_q <= s3_enx_d_q;
      end else begin
        s4_n0_q <= s3_eny_n_q;
        s4_d0_q <= s3_eny_d_q;
      end
      if (s3_pex_x_q < s3_pex_y_q) begin
        s4_n1_q <= s3_exx_n_q;
        s4_d1_q <= s3_exx_d_q;
      end else begin
        s4_n1_q <= s3_exy_n_q;
        s4_d1_q <= s3_exy_d_q;
      end
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Entry/exit ordering products and the four interpolation dividends.
  logic                 s5_vld_q, s5_ok_q, s5_sx_q, s5_sy_q;
  logic signed [CW-1:0] s5_x1_q, s5_y1_q;
  logic [EW-1:0]        s5_d0_q, s5_d1_q;
  logic [PW-1:0]        s5_f0_q, s5_f1_q;
  logic [NUM_LANES-1:0][PW-1:0] s5_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_vld_q <= 1'b0;
    else if (adv) s5_vld_q <= s4_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_ok_q     <= s4_ok_q;
      s5_sx_q     <= s4_sx_q;
      s5_sy_q     <= s4_sy_q;
      s5_x1_q     <= s4_x1_q;
      s5_y1_q     <= s4_y1_q;
      s5_d0_q     <= s4_d0_q;
      s5_d1_q     <= s4_d1_q;
      s5_f0_q     <= PW'(s4_n0_q) * PW'(s4_d1_q);
      s5_f1_q     <= PW'(s4_n1_q) * PW'(s4_d0_q);
      s5_num_q[0] <= PW'(s4_adx_q) * PW'(s4_n0_q);
      s5_num_q[1] <= PW'(s4_ady_q) * PW'(s4_n0_q);
      s5_num_q[2] <= PW'(s4_adx_q) * PW'(s4_n1_q);
      s5_num_q[3] <= PW'(s4_ady_q) * PW'(s4_n1_q);
    end
  end

  // ---------------------------------------------------------------- divider
  logic                          vis;
  logic [NUM_LANES-1:0][EW-1:0]  div_den;
  logic [SW-1:0]                 div_side_in, div_side_out;
  logic                          div_vld;
  logic [NUM_LANES-1:0][EW-1:0]  div_quot;
  logic [NUM_LANES-1:0]          div_rnz;

  assign vis         = s5_ok_q & (s5_f0_q <= s5_f1_q);
  assign div_den     = {s5_d1_q, s5_d1_q, s5_d0_q, s5_d0_q};
  assign div_side_in = {vis, s5_x1_q, s5_y1_q, s5_sx_q, s5_sy_q};

  nlnc_div #(
    .CW (CW),
    .SW (SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s5_vld_q),
    .num_i  (s5_num_q),
    .den_i  (div_den),
    .side_i (div_side_in),
    .vld_o  (div_vld),
    .quot_o (div_quot),
    .rnz_o  (div_rnz),
    .side_o (div_side_out)
  );

  // ---------------------------------------------------------------- output
  // c +/- q with the fraction truncated toward zero.
  logic                 o_vis, o_sx, o_sy;
  logic signed [CW-1:0] o_x1, o_y1;
  logic [NUM_LANES-1:0][CW-1:0] o_res;

  assign {o_vis, o_x1, o_y1, o_sx, o_sy} = div_side_out;

  always_comb begin
    logic signed [TW-1:0] c, q, t, r;
    logic                 neg;
    for (int l = 0; l < NUM_LANES; l++) begin
      c   = (l % 2 == 0) ? TW'(o_x1) : TW'(o_y1);
      neg = (l % 2 == 0) ? o_sx : o_sy;
      q   = $signed({1'b0, div_quot[l]});
      if (!neg) begin
        t = c + q;
        r = (div_rnz[l] && t < 0) ? t + TW'(1) : t;
      end else begin
        t = c - q;
        r = (div_rnz[l] && t > 0) ? t - TW'(1) : t;
      end
      o_res[l] = o_vis ? r[CW-1:0] : '0;
    end
  end

  logic                 out_vis_q;
  logic [4*CW-1:0]      out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= div_vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_vis_q  <= o_vis;
      out_data_q <= o_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_vis_q;
  assign m_axis_tdata  = TDW'(out_data_q);

endmodule

>>> tb/sv/tb.sv
module tb;
  import nlnc_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int DW = ((4*CW+7)/8)*8;
  localparam int LAT = CW + 7;
  localparam int WDOG_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic   vis;
    coord_t sx, sy, ex, ey;
  } clip_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [DW-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_CLIP_LEFT;
  logic [CW-1:0] cfg_data_i = '0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit hold_sink = 1'b0;
  int unsigned n_fail = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  nln_line_clipper_top #(.COORD_WIDTH(CW)) u_top (.*);

  // Scoreboard: keeps its own copy of the window and predicts each clip.
  class clip_scoreboard;
    longint win_l = RST_CLIP_LEFT, win_t = RST_CLIP_TOP;
    longint win_r = RST_CLIP_RIGHT, win_b = RST_CLIP_BOTTOM;
    clip_res_t pending[$];

    function void set_edge(logic [CFG_IDX_W-1:0] idx, coord_t v);
      case (idx)
        REG_CLIP_LEFT:   win_l = v;
        REG_CLIP_TOP:    win_t = v;
        REG_CLIP_RIGHT:  win_r = v;
        REG_CLIP_BOTTOM: win_b = v;
        default: ;
      endcase
    endfunction

    // signed compare of n1/d1 against n2/d2, denominators positive; products fit 64 bits
    function int frac_cmp(longint n1, longint d1, longint n2, longint d2);
      longint a, b;
      a = n1 * d2;
      b = n2 * d1;
      return (a < b) ? -1 : (a > b) ? 1 : 0;
    endfunction

    // trunc(c + s*n/d) toward zero, computed exactly
    function longint lerp_trunc(longint c, longint s, longint n, longint d);
      longint num, q;
      num = c * d + s * n;
      q = num / d;   // SV division truncates toward zero
      return q;
    endfunction

    function void note_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
      longint dx, dy, n0, d0, n1, d1;
      longint p[4], q[4];
      bit ok;
      clip_res_t r;
      dx = longint'(x2) - x1;
      dy = longint'(y2) - y1;
      n0 = 0; d0 = 1; n1 = 1; d1 = 1; ok = 1;
      p[0] = -dx; q[0] = x1 - win_l;
      p[1] = dx;  q[1] = win_r - x1;
      p[2] = -dy; q[2] = y1 - win_t;
      p[3] = dy;  q[3] = win_b - y1;
      for (int i = 0; i < 4; i++) begin
        if (p[i] == 0) begin
          if (q[i] < 0) ok = 0;
        end else if (p[i] < 0) begin
          if (frac_cmp(-q[i], -p[i], n0, d0) > 0) begin
            n0 = -q[i]; d0 = -p[i];
          end
        end else if (frac_cmp(q[i], p[i], n1, d1) < 0) begin
          n1 = q[i]; d1 = p[i];
        end
      end
      r = '0;
      if (ok && frac_cmp(n0, d0, n1, d1) <= 0) begin
        r.vis = 1'b1;
        r.sx = coord_t'(lerp_trunc(x1, dx, n0, d0));
        r.sy = coord_t'(lerp_trunc(y1, dy, n0, d0));
        r.ex = coord_t'(lerp_trunc(x1, dx, n1, d1));
        r.ey = coord_t'(lerp_trunc(y1, dy, n1, d1));
      end
      pending.push_back(r);
    endfunction

    function int check_clip(clip_res_t got);
      clip_res_t e;
      int bad;
      bad = 0;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", got);
        return 1;
      end
      e = pending.pop_front();
      if (got.vis !== e.vis) begin
        $error("visible: expected %0d actual %0d", e.vis, got.vis); bad++;
      end
      if (got.sx !== e.sx) begin
        $error("clipped_start_x: expected %0d actual %0d", e.sx, got.sx); bad++;
      end
      if (got.sy !== e.sy) begin
        $error("clipped_start_y: expected %0d actual %0d", e.sy, got.sy); bad++;
      end
      if (got.ex !== e.ex) begin
        $error("clipped_end_x: expected %0d actual %0d", e.ex, got.ex); bad++;
      end
      if (got.ey !== e.ey) begin
        $error("clipped_end_y: expected %0d actual %0d", e.ey, got.ey); bad++;
      end
      return bad;
    endfunction
  endclass

  clip_scoreboard sb = new();

  // Output side: sample at the rising edge, ready changes at the falling edge.
  // Struct order is visible, start x, start y, end x, end y.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      n_fail += sb.check_clip({m_axis_tuser, m_axis_tdata[CW-1:0],
                               m_axis_tdata[2*CW-1:CW], m_axis_tdata[3*CW-1:2*CW],
                               m_axis_tdata[4*CW-1:3*CW]});
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_edge(logic [CFG_IDX_W-1:0] idx, coord_t v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_edge(idx, v);
  endtask

  task automatic set_window(coord_t l, coord_t t, coord_t r, coord_t b);
    write_edge(REG_CLIP_LEFT, l);
    write_edge(REG_CLIP_TOP, t);
    write_edge(REG_CLIP_RIGHT, r);
    write_edge(REG_CLIP_BOTTOM, b);
  endtask

  // Offer one segment; valid stays up across back-to-back words.
  task automatic send_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {{(DW-4*CW){1'b0}}, y2, x2, y1, x1};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_segment(x1, y1, x2, y2);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Coordinate near the window, sometimes anywhere in range.
  function automatic coord_t pick(longint lo, longint hi);
    longint span;
    if ($urandom_range(9) == 0) return coord_t'($urandom);
    span = hi - lo + 1;
    if (span < 1) span = 1;
    return coord_t'(lo - span/2 + longint'($urandom_range(2*span)));
  endfunction

  task automatic random_segments(int n);
    coord_t x1, y1, x2, y2;
    repeat (n) begin
      x1 = pick(sb.win_l, sb.win_r);
      y1 = pick(sb.win_t, sb.win_b);
      case ($urandom_range(7))
        0: begin x2 = x1; y2 = pick(sb.win_t, sb.win_b); end  // vertical
        1: begin y2 = y1; x2 = pick(sb.win_l, sb.win_r); end  // horizontal
        2: begin x2 = x1; y2 = y1; end                        // point
        default: begin
          x2 = pick(sb.win_l, sb.win_r);
          y2 = pick(sb.win_t, sb.win_b);
        end
      endcase
      send_segment(x1, y1, x2, y2);
    end
  endtask

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, default window
    send_segment(100, 100, 200, 200);      // fully inside
    send_segment(-50, 240, 700, 240);      // crosses both sides
    send_segment(-10, -10, 700, 500);      // diagonal across the window
    send_segment(-100, -5, -1, -200);      // outside
    send_segment(0, 0, 0, 0);              // point on corner
    send_segment(700, 700, 700, 700);      // point outside
    send_segment(-10, 10, 10, -10);        // touches corner only
    send_segment(320, -100, 320, 600);     // vertical
    send_segment(320, 600, 320, 700);      // vertical, outside
    send_segment(CMIN, CMIN, CMAX, CMAX);  // full range diagonal
    send_segment(CMAX, CMIN, CMIN, CMAX);
    send_segment(CMAX, 0, CMIN, 479);
    send_segment(-1, -1, -1, -1);
    send_segment(639, 479, 1000, 1000);    // leaves at corner
    drain();
    set_window(CMIN, CMIN, CMAX, CMAX);    // widest window
    send_segment(CMIN, CMAX, CMAX, CMIN);
    send_segment(5, -7, -3, 11);
    drain();
    set_window(10, 10, 5, 20);             // inverted window
    send_segment(0, 0, 30, 30);
    send_segment(7, 15, 7, 15);
    drain();
    set_window(-3, -3, -3, -3);            // single point window
    send_segment(-10, -3, 10, -3);
    send_segment(-3, -3, -3, -3);
    drain();

    // random, sender 29 / receiver 68 idle
    set_window(-200, -150, 300, 250);
    src_idle_pct = 29; snk_idle_pct = 68;
    random_segments(250);

    // long receiver stall while the sender keeps going
    fork
      begin
        hold_sink = 1'b1;
        repeat (LAT * 4) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      random_segments(60);
    join
    drain();

    set_window(CMIN, -1000, -100, CMAX);
    src_idle_pct = 68; snk_idle_pct = 29;
    random_segments(250);
    drain();

    set_window(0, 0, 639, 479);
    src_idle_pct = 0; snk_idle_pct = 0;
    random_segments(250);
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LAT + 5) @(negedge clk_i);
    if (n_fail == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
